FILE: hw/rtl/peer_table_with_aging_core_defines.svh
// ----------------------------------------------------------------------------
// peer table assertion macros
// concurrent check helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef PEER_TABLE_WITH_AGING_CORE_DEFINES_SVH
`define PEER_TABLE_WITH_AGING_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PTA_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PTA_ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTA_ASSERT_RST(label, clk, rst_n, prop, msg)
`define PTA_ASSERT_CLK(label, clk, prop, msg)
`endif

`endif

FILE: hw/rtl/pta_pkg.sv
// ----------------------------------------------------------------------------
// peer table package
// sizes, probe beat type, state codes and result packing helpers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pta_pkg;

    localparam int PEER_SLOTS    = 16;
    localparam int IDX_W         = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam int CNT_W         = $clog2(PEER_SLOTS + 1);
    localparam int MAC_W         = 48;
    localparam int TIME_W        = 32;
    localparam int HEIGHT_W      = 32;
    localparam int CAPS_W        = 8;
    localparam int TMO_W         = 16;
    localparam int SLOT_OUT_W    = 4;
    localparam int COUNT_OUT_W   = 5;
    localparam int IN_TDATA_W    = 120;
    localparam int OUT_TDATA_W   = 16;
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd300;

    typedef enum logic [1:0] {
        OP_MATCH,
        OP_WRITE,
        OP_PRUNE
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_WRITE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                vld;
        t_op                 op;
        logic [IDX_W-1:0]    pos;
        logic [MAC_W-1:0]    mac;
        logic [HEIGHT_W-1:0] height;
        logic [CAPS_W-1:0]   caps;
        logic [TIME_W-1:0]   now;
        logic [TMO_W-1:0]    timeout;
        logic                hit;
        logic [IDX_W-1:0]    hit_idx;
        logic                claim;
        logic                free_vld;
        logic [IDX_W-1:0]    free_idx;
        logic [CNT_W-1:0]    count;
    } t_probe;

    function automatic logic [SLOT_OUT_W-1:0] slot_out(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_OUT_W-1:0] ext;
        ext = {{SLOT_OUT_W{1'b0}}, idx};
        return ext[SLOT_OUT_W-1:0];
    endfunction

    function automatic logic [COUNT_OUT_W-1:0] count_out(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+COUNT_OUT_W-1:0] ext;
        ext = {{COUNT_OUT_W{1'b0}}, cnt};
        return ext[COUNT_OUT_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/pta_cell.sv
// ----------------------------------------------------------------------------
// peer table cell
// holds one table entry and passes the probe beat on to the next cell
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pta_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pta_pkg::t_probe i_probe,
    output pta_pkg::t_probe o_probe
);

    logic                         r_valid;
    logic [pta_pkg::MAC_W-1:0]    r_mac;
    logic [pta_pkg::TIME_W-1:0]   r_last;
    logic [pta_pkg::HEIGHT_W-1:0] r_height;
    logic [pta_pkg::CAPS_W-1:0]   r_caps;
    logic                         r_probe_vld;
    pta_pkg::t_probe              r_probe;

    logic                         n_valid;
    logic [pta_pkg::MAC_W-1:0]    n_mac;
    logic                         n_write;
    pta_pkg::t_probe              n_probe;
    logic [pta_pkg::TIME_W-1:0]   w_age;
    logic                         w_stale;

    assign w_age   = i_probe.now - r_last;
    assign w_stale = r_valid && (w_age > {{(pta_pkg::TIME_W-pta_pkg::TMO_W){1'b0}},
                                          i_probe.timeout});

    always_comb begin
        n_valid = r_valid;
        n_mac   = r_mac;
        n_write = 1'b0;
        n_probe = i_probe;
        n_probe.pos = i_probe.pos + pta_pkg::IDX_W'(1);
        if (i_probe.vld) begin
            case (i_probe.op)
                pta_pkg::OP_MATCH: begin
                    if (!i_probe.hit && r_valid && r_mac == i_probe.mac) begin
                        n_probe.hit     = 1'b1;
                        n_probe.hit_idx = i_probe.pos;
                    end
                    if (!i_probe.free_vld && !r_valid) begin
                        n_probe.free_vld = 1'b1;
                        n_probe.free_idx = i_probe.pos;
                    end
                end
                pta_pkg::OP_WRITE: begin
                    if (i_probe.hit && i_probe.hit_idx == i_probe.pos) begin
                        n_write = 1'b1;
                        if (i_probe.claim) begin
                            n_valid = 1'b1;
                            n_mac   = i_probe.mac;
                        end
                    end
                end
                pta_pkg::OP_PRUNE: begin
                    if (w_stale) begin
                        n_valid = 1'b0;
                        n_mac   = '0;
                    end
                    n_probe.count = i_probe.count + pta_pkg::CNT_W'(n_valid);
                end
                default: begin
                    n_probe = i_probe;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_mac       <= '0;
            r_probe_vld <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_mac       <= n_mac;
            r_probe_vld <= n_probe.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe <= n_probe;
        if (n_write) begin
            r_last   <= i_probe.now;
            r_height <= i_probe.height;
            r_caps   <= i_probe.caps;
        end
    end

    always_comb begin
        o_probe     = r_probe;
        o_probe.vld = r_probe_vld;
    end

endmodule

FILE: hw/rtl/peer_table_with_aging_core.sv
// a prune or a table-full beacon gives its result after one probe pass down the chain,
// a stored beacon after two (a match pass, then a write pass); the result is then
// registered in ST_EMIT, which holds while the output is stalled by i_m_axis_tready
// one beat in flight: no new beat is taken until the result of the last is emitted
// reset: synchronous active low, clears all valid bits, the count and the
// timeout (back to 300); no clearing pass, the block is ready the cycle after
`timescale 1ns / 1ps
`include "peer_table_with_aging_core_defines.svh"

// ----------------------------------------------------------------------------
// peer table with aging core
// neighbor table in a chain of entry cells walked by a probe beat
// ----------------------------------------------------------------------------
module peer_table_with_aging_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pta_pkg::TMO_W-1:0]          i_cfg_wdata,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // peer_mac, peer_height, peer_caps, now_sec
    input  logic [pta_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // cmd
    input  logic                               i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // slot_index, stored, active_count, zero fill
    output logic [pta_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    pta_pkg::t_state                  r_state, n_state;
    logic [pta_pkg::TMO_W-1:0]        r_timeout;
    logic [pta_pkg::CNT_W-1:0]        r_pruned, n_pruned;
    logic                             r_cmd, n_cmd;
    logic [pta_pkg::MAC_W-1:0]        r_mac, n_mac;
    logic [pta_pkg::HEIGHT_W-1:0]     r_height, n_height;
    logic [pta_pkg::CAPS_W-1:0]       r_caps, n_caps;
    logic [pta_pkg::TIME_W-1:0]       r_now, n_now;
    logic [pta_pkg::IDX_W-1:0]        r_res_slot, n_res_slot;
    logic                             r_res_stored, n_res_stored;
    logic                             r_out_vld, n_out_vld;
    logic [pta_pkg::OUT_TDATA_W-1:0]  r_out_data, n_out_data;

    pta_pkg::t_probe                  w_head;
    pta_pkg::t_probe                  w_link [pta_pkg::PEER_SLOTS+1];
    pta_pkg::t_probe                  w_tail;
    logic                             w_accept;
    logic                             w_waiting;
    logic [pta_pkg::PEER_SLOTS-1:0]   w_vld_vec;

    assign w_link[0]       = w_head;
    assign w_tail          = w_link[pta_pkg::PEER_SLOTS];
    assign o_s_axis_tready = (r_state == pta_pkg::ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_waiting       = (r_state == pta_pkg::ST_MATCH) || (r_state == pta_pkg::ST_WRITE);

    always_comb begin
        n_state      = r_state;
        n_pruned     = r_pruned;
        n_cmd        = r_cmd;
        n_mac        = r_mac;
        n_height     = r_height;
        n_caps       = r_caps;
        n_now        = r_now;
        n_res_slot   = r_res_slot;
        n_res_stored = r_res_stored;
        n_out_vld    = r_out_vld && !i_m_axis_tready;
        n_out_data   = r_out_data;

        w_head          = '0;
        w_head.op       = pta_pkg::OP_MATCH;
        w_head.mac      = r_mac;
        w_head.height   = r_height;
        w_head.caps     = r_caps;
        w_head.now      = r_now;
        w_head.timeout  = r_timeout;

        case (r_state)
            pta_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_cmd    = i_s_axis_tuser;
                    n_mac    = i_s_axis_tdata[47:0];
                    n_height = i_s_axis_tdata[79:48];
                    n_caps   = i_s_axis_tdata[87:80];
                    n_now    = i_s_axis_tdata[119:88];
                    w_head.vld    = 1'b1;
                    w_head.op     = i_s_axis_tuser ? pta_pkg::OP_PRUNE
                                                   : pta_pkg::OP_MATCH;
                    w_head.mac    = i_s_axis_tdata[47:0];
                    w_head.height = i_s_axis_tdata[79:48];
                    w_head.caps   = i_s_axis_tdata[87:80];
                    w_head.now    = i_s_axis_tdata[119:88];
                    n_state = pta_pkg::ST_MATCH;
                end
            end
            pta_pkg::ST_MATCH: begin
                if (w_tail.vld) begin
                    n_res_slot   = '0;
                    n_res_stored = 1'b0;
                    n_state      = pta_pkg::ST_EMIT;
                    if (r_cmd) begin
                        n_pruned = w_tail.count;
                    end else if (w_tail.hit || w_tail.free_vld) begin
                        n_res_slot   = w_tail.hit ? w_tail.hit_idx : w_tail.free_idx;
                        n_res_stored = 1'b1;
                        w_head.vld     = 1'b1;
                        w_head.op      = pta_pkg::OP_WRITE;
                        w_head.hit     = 1'b1;
                        w_head.hit_idx = n_res_slot;
                        w_head.claim   = !w_tail.hit;
                        n_state = pta_pkg::ST_WRITE;
                    end
                end
            end
            pta_pkg::ST_WRITE: begin
                if (w_tail.vld) begin
                    n_state = pta_pkg::ST_EMIT;
                end
            end
            pta_pkg::ST_EMIT: begin
                if (!r_out_vld || i_m_axis_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {6'b0, pta_pkg::count_out(r_pruned), r_res_stored,
                                  pta_pkg::slot_out(r_res_slot)};
                    n_state    = pta_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pta_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pta_pkg::ST_IDLE;
            r_timeout <= pta_pkg::TIMEOUT_RESET;
            r_pruned  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pruned  <= n_pruned;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_mac        <= n_mac;
        r_height     <= n_height;
        r_caps       <= n_caps;
        r_now        <= n_now;
        r_res_slot   <= n_res_slot;
        r_res_stored <= n_res_stored;
        r_out_data   <= n_out_data;
    end

    for (genvar g = 0; g < pta_pkg::PEER_SLOTS; g++) begin : g_cell
        pta_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_probe (w_link[g]),
            .o_probe (w_link[g+1])
        );
    end

    // registered probe stages only, the head may overlap the tail
    for (genvar g = 0; g < pta_pkg::PEER_SLOTS; g++) begin : g_vld
        assign w_vld_vec[g] = w_link[g+1].vld;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    `PTA_ASSERT_RST(a_launch, i_clk, i_rst_n, w_accept |=> w_link[1].vld, "probe not launched")
    `PTA_ASSERT_RST(a_one_probe, i_clk, i_rst_n, $countones(w_vld_vec) <= 1, "two probes in chain")
    `PTA_ASSERT_RST(a_tail_state, i_clk, i_rst_n, w_tail.vld |-> w_waiting, "stray probe at tail")
    `PTA_ASSERT_CLK(a_rst_out, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

endmodule
